[rtl/bit_fifo_with_byte_ops_unit_defines.svh]
// assertion macros for the bit fifo unit
// expects clk and rst in the scope of the module that uses them
`ifndef BIT_FIFO_WITH_BYTE_OPS_UNIT_DEFINES_SVH
`define BIT_FIFO_WITH_BYTE_OPS_UNIT_DEFINES_SVH

// checked only while out of reset
`define BFB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define BFB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/bfb_pkg.sv]
// shared types and codes for the bit fifo unit
// request and result structs, controller/datapath command and status structs
package bfb_pkg;

  // bits held at most; fill_count is sized for this depth
  localparam int unsigned CAPACITY_BITS = 1024;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned FILL_W   = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BYTE_MSB = 7;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INS_BIT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BYTE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_BIT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_BYTE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSPECT  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                bit_value;
    logic [BYTE_W-1:0]   byte_value;
    logic [OFFSET_W-1:0] offset;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_data;
    logic [FILL_W-1:0]   fill_count;
    logic [STATUS_W-1:0] status;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture request
    logic decide;  // clear read data, load status
    logic wr;      // write one bit at the tail
    logic rd;      // read one bit at the head and pop it
    logic peek;    // read one bit at head plus offset
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] code;
  } dp_sts_t;

endpackage

[rtl/bfb_datapath.sv]
// datapath of the bit fifo unit: bit memory, pointers, fill count, shifters
// depends on bfb_pkg; driven by bfb_ctrl through dp_cmd_t
module bfb_datapath import bfb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output res_t    result
);

  localparam int unsigned PTR_W = $clog2(CAPACITY_BITS);
  localparam int unsigned CNT_W = $clog2(CAPACITY_BITS + 1);
  localparam int unsigned CMP_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;
  localparam int unsigned SUM_W = ((CMP_W > PTR_W) ? CMP_W : PTR_W) + 1;

  localparam logic [PTR_W-1:0] PTR_LAST     = PTR_W'(CAPACITY_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(CAPACITY_BITS);
  localparam logic [CNT_W-1:0] CNT_BYTE_MAX = CNT_W'(CAPACITY_BITS - BYTE_W);
  localparam logic [CNT_W-1:0] CNT_BYTE     = CNT_W'(BYTE_W);
  localparam logic [SUM_W-1:0] SUM_CAP      = SUM_W'(CAPACITY_BITS);

  logic                mem [CAPACITY_BITS];
  logic                mem_q;
  req_t                req_q;
  logic [BYTE_W-1:0]   byte_sh;
  logic [BYTE_W-1:0]   data;
  logic [STATUS_W-1:0] status;
  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    rp;
  logic [CNT_W-1:0]    cnt;
  logic                rd_pending;

  logic [STATUS_W-1:0] code;
  logic                wr_bit;
  logic [SUM_W-1:0]    peek_sum;
  logic [SUM_W-1:0]    peek_wrap;
  logic [PTR_W-1:0]    rd_addr;
  logic [PTR_W-1:0]    wp_next;
  logic [PTR_W-1:0]    rp_next;

  // refusal check on the held request
  always_comb begin
    code = ST_OK;
    case (req_q.kind)
      KIND_INS_BIT:  if (cnt == CNT_FULL) code = ST_OVERFLOW;
      KIND_INS_BYTE: if (cnt > CNT_BYTE_MAX) code = ST_OVERFLOW;
      KIND_REM_BIT:  if (cnt == '0) code = ST_UNDERFLOW;
      KIND_REM_BYTE: if (cnt < CNT_BYTE) code = ST_UNDERFLOW;
      KIND_INSPECT:  if (CMP_W'(req_q.offset) >= CMP_W'(cnt)) code = ST_RANGE;
      default:       code = ST_OK;
    endcase
  end

  assign sts.kind = req_q.kind;
  assign sts.code = code;

  // offset is below the fill count here, so one subtract wraps it
  assign peek_sum  = SUM_W'(rp) + SUM_W'(req_q.offset);
  assign peek_wrap = (peek_sum >= SUM_CAP) ? (peek_sum - SUM_CAP) : peek_sum;
  assign rd_addr   = cmd.peek ? PTR_W'(peek_wrap) : rp;

  assign wp_next = (wp == PTR_LAST) ? '0 : wp + 1'b1;
  assign rp_next = (rp == PTR_LAST) ? '0 : rp + 1'b1;
  assign wr_bit  = (req_q.kind == KIND_INS_BIT) ? req_q.bit_value : byte_sh[BYTE_MSB];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wp] <= wr_bit;
    end
    if (cmd.rd || cmd.peek) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q   <= req;
      byte_sh <= req.byte_value;
    end else if (cmd.wr) begin
      byte_sh <= {byte_sh[BYTE_MSB-1:0], 1'b0};
    end
    if (cmd.decide) begin
      data   <= '0;
      status <= code;
    end else if (rd_pending) begin
      data <= {data[BYTE_MSB-1:0], mem_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      cnt        <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.rd || cmd.peek;
      if (cmd.wr) begin
        wp  <= wp_next;
        cnt <= cnt + 1'b1;
      end else if (cmd.rd) begin
        rp  <= rp_next;
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign result.read_data  = data;
  assign result.fill_count = FILL_W'(cnt);
  assign result.status     = status;

endmodule

[rtl/bfb_ctrl.sv]
// controller of the bit fifo unit: sequences one request at a time
// depends on bfb_pkg; drives bfb_datapath through dp_cmd_t
module bfb_ctrl import bfb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_WRITE  = 7'b0000100,
    S_READ   = 7'b0001000,
    S_PEEK   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] steps;
  logic [2:0] steps_next;

  always_comb begin
    state_next = state;
    steps_next = steps;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_DONE;
        if (sts.code == ST_OK) begin
          case (sts.kind)
            KIND_INS_BIT: begin
              steps_next = '0;
              state_next = S_WRITE;
            end
            KIND_INS_BYTE: begin
              steps_next = 3'(BYTE_MSB);
              state_next = S_WRITE;
            end
            KIND_REM_BIT: begin
              steps_next = '0;
              state_next = S_READ;
            end
            KIND_REM_BYTE: begin
              steps_next = 3'(BYTE_MSB);
              state_next = S_READ;
            end
            KIND_INSPECT:  state_next = S_PEEK;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (steps == '0) begin
          state_next = S_DONE;
        end else begin
          steps_next = steps - 1'b1;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (steps == '0) begin
          state_next = S_DRAIN;
        end else begin
          steps_next = steps - 1'b1;
        end
      end
      S_PEEK: begin
        cmd.peek   = 1'b1;
        state_next = S_DRAIN;
      end
      // last read bit shifts into the result here
      S_DRAIN: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

[rtl/bit_fifo_with_byte_ops_unit.sv]
// Circular FIFO of single bits with bit and byte insert/remove and inspect.
// A request is taken when start is high and busy is low; its one result is on
// result for the single cycle that done is high, and the receiver cannot stall
// it. The bits live in a single-port memory that moves one bit per cycle, so a
// request passes from acceptance through decide, then the bit writes (insert),
// the bit reads and a drain (remove) or a peek and a drain (inspect), then done;
// a refused request or one of an unused kind goes from decide to done. The fill
// count reports up to CAPACITY_BITS; the memory needs no clearing after reset.
// top level; depends on bfb_pkg, bfb_ctrl, bfb_datapath and the defines header
`include "bit_fifo_with_byte_ops_unit_defines.svh"

module bit_fifo_with_byte_ops_unit import bfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output res_t result
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bfb_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  `BFB_ASSERT(a_done_while_busy, done |-> busy, "result strobe outside a request")
  `BFB_ASSERT(a_accept_no_done, (start && !busy) |=> (busy && !done), "result after accept")
  `BFB_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `BFB_ASSERT_ALWAYS(a_refused_no_change, (!rst && done && result.status != ST_OK) |-> $stable(result.fill_count), "refused request moved the fill count")

endmodule
